@@ rtl/core/utf8_to_utf16_transcoder_unit_macros.svh @@
// Assertion macros shared by the transcoder RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef UTF8_TO_UTF16_TRANSCODER_UNIT_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that prop holds at every clock edge outside reset
`define UTU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("utu: property violated");

// Check that cond is never true outside reset
`define UTU_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("utu: forbidden condition seen");

`else

`define UTU_ASSERT(lbl, clk, rstn, prop)
`define UTU_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

@@ rtl/core/utu_pkg.sv @@
`default_nettype none

package utu_pkg;

  // UTF-16 surrogate bases and the supplementary plane range
  localparam logic [15:0] SURR_HI_BASE = 16'hD800;
  localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;

  // One accepted input item
  typedef struct packed {
    logic       string_end;
    logic [7:0] in_byte;
  } in_item_t;

  // All results caused by one input byte: up to two units, then a status
  typedef struct packed {
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic [1:0]  n_units;
    logic        status;
    logic        err;
  } bundle_t;

endpackage

`default_nettype wire

@@ rtl/core/utf8_to_utf16_transcoder_unit.sv @@
// UTF-8 to UTF-16 stream transcoder.
// Slave stream: one UTF-8 byte per item in tdata, tlast marks the last byte
// of a string. Master stream: one item per UTF-16 code unit, and after the
// last byte of a string one status item (tuser = 1) whose tdata[16] is set
// when the string failed to convert. tlast marks the last item that a
// byte causes. A byte causes zero, one or two units, plus the status item.
// The first result of an accepted byte reaches the master stream through the
// input register, then decode into the result register, once that register
// is free to load it.
// Throughput: one byte per cycle while tready is high and each byte gives at
// most one result; a byte with more holds the result register until all are
// taken, which sets the rate for surrogate pairs and string ends with a unit.
// Stalls: when tready is low the current item holds and the skid register
// takes one more byte, then s_axis_tready_o falls.
// Reset: all streams empty, decoder expects a lead byte of a new string.
`default_nettype none

module utf8_to_utf16_transcoder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic        s_axis_tlast_i,   // string_end
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // [15:0] code_unit, [16] string_error
  output logic [0:0]       m_axis_tuser_o,   // [0] is_status
  output logic             m_axis_tlast_o    // run_last
);

  utu_pkg::in_item_t in_item;
  utu_pkg::in_item_t dec_item;
  utu_pkg::bundle_t  bnd;
  logic              dec_valid;
  logic              dec_ready;
  logic              bnd_valid;
  logic              bnd_ready;
  logic [15:0]       code_unit;
  logic              is_status;
  logic              string_error;

  assign in_item.in_byte    = s_axis_tdata_i;
  assign in_item.string_end = s_axis_tlast_i;

  utu_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (in_item),
    .out_valid_o (dec_valid),
    .out_ready_i (dec_ready),
    .out_item_o  (dec_item)
  );

  utu_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dec_valid),
    .in_ready_o  (dec_ready),
    .in_item_i   (dec_item),
    .bnd_valid_o (bnd_valid),
    .bnd_ready_i (bnd_ready),
    .bnd_o       (bnd)
  );

  utu_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bnd_valid_i    (bnd_valid),
    .bnd_ready_o    (bnd_ready),
    .bnd_i          (bnd),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .code_unit_o    (code_unit),
    .is_status_o    (is_status),
    .string_error_o (string_error),
    .run_last_o     (m_axis_tlast_o)
  );

  // Pack the result item
  assign m_axis_tdata_o = {7'b0, string_error, code_unit};
  assign m_axis_tuser_o = is_status;

endmodule

`default_nettype wire

@@ rtl/core/utu_skid.sv @@
`default_nettype none

module utu_skid (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire utu_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output utu_pkg::in_item_t      out_item_o
);

  logic              main_valid_q, main_valid_d;
  logic              skid_valid_q, skid_valid_d;
  utu_pkg::in_item_t main_q, main_d;
  utu_pkg::in_item_t skid_q, skid_d;
  logic              push;
  logic              drain;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_item_o  = main_q;

  assign push  = in_valid_i && in_ready_o;
  assign drain = !main_valid_q || out_ready_i;

  // Refill the main stage from the skid stage first, then from the input
  always_comb begin
    main_valid_d = main_valid_q;
    main_d       = main_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (drain) begin
      if (skid_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else if (push) begin
        main_valid_d = 1'b1;
        main_d       = in_item_i;
      end else begin
        main_valid_d = 1'b0;
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_d       = in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

@@ rtl/core/utu_decode.sv @@
`default_nettype none
`include "utf8_to_utf16_transcoder_unit_macros.svh"

module utu_decode (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire utu_pkg::in_item_t in_item_i,
  output logic                   bnd_valid_o,
  input  wire logic              bnd_ready_i,
  output utu_pkg::bundle_t       bnd_o
);

  logic [1:0]  pend_q, pend_d;
  logic [2:0]  len_q, len_d;
  logic [20:0] acc_q, acc_d;
  logic        fail_q, fail_d;
  logic [20:0] acc_sh;
  logic [20:0] supp_off;
  logic [7:0]  b;
  logic        fire;

  assign b           = in_item_i.in_byte;
  assign in_ready_o  = bnd_ready_i;
  assign bnd_valid_o = in_valid_i;
  assign fire        = in_valid_i && bnd_ready_i;

  assign acc_sh   = {acc_q[14:0], b[5:0]};
  assign supp_off = acc_sh - utu_pkg::SUPP_BASE;

  // Decode one byte against the running sequence state
  always_comb begin
    pend_d = pend_q;
    len_d  = len_q;
    acc_d  = acc_q;
    fail_d = fail_q;
    bnd_o  = '0;
    if (!fail_q) begin
      if (pend_q == 2'd0) begin
        if (!b[7]) begin
          bnd_o.unit0   = {8'h00, b};
          bnd_o.n_units = 2'd1;
        end else if (b[7:5] == 3'b110) begin
          acc_d  = {16'b0, b[4:0]};
          pend_d = 2'd1;
          len_d  = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
          acc_d  = {17'b0, b[3:0]};
          pend_d = 2'd2;
          len_d  = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
          acc_d  = {18'b0, b[2:0]};
          pend_d = 2'd3;
          len_d  = 3'd4;
        end else begin
          fail_d = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        // Drop the partial sequence on a bad continuation byte
        fail_d = 1'b1;
        pend_d = 2'd0;
        len_d  = 3'd0;
        acc_d  = '0;
      end else begin
        acc_d  = acc_sh;
        pend_d = pend_q - 2'd1;
        if (pend_q == 2'd1) begin
          if (len_q == 3'd4) begin
            if (acc_sh >= utu_pkg::SUPP_BASE && acc_sh <= utu_pkg::CP_MAX) begin
              bnd_o.unit0   = utu_pkg::SURR_HI_BASE | {6'b0, supp_off[19:10]};
              bnd_o.unit1   = utu_pkg::SURR_LO_BASE | {6'b0, supp_off[9:0]};
              bnd_o.n_units = 2'd2;
            end else begin
              fail_d = 1'b1;
            end
          end else begin
            bnd_o.unit0   = acc_sh[15:0];
            bnd_o.n_units = 2'd1;
          end
          len_d = 3'd0;
          acc_d = '0;
        end
      end
    end
    bnd_o.status = in_item_i.string_end;
    bnd_o.err    = in_item_i.string_end && (fail_d || (pend_d != 2'd0));
    // Return to the idle state at the end of the string
    if (in_item_i.string_end) begin
      pend_d = 2'd0;
      len_d  = 3'd0;
      acc_d  = '0;
      fail_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      len_q  <= 3'd0;
      acc_q  <= '0;
      fail_q <= 1'b0;
    end else if (fire) begin
      pend_q <= pend_d;
      len_q  <= len_d;
      acc_q  <= acc_d;
      fail_q <= fail_d;
    end
  end

  `UTU_ASSERT_NEVER(a_fail_with_pending, clk_i, rst_ni, fail_q && (pend_q != 2'd0))
  `UTU_ASSERT(a_len_tracks_pending, clk_i, rst_ni,
              (pend_q != 2'd0) |-> (len_q > {1'b0, pend_q}))
  `UTU_ASSERT(a_end_clears_state, clk_i, rst_ni,
              (fire && in_item_i.string_end) |=> ((pend_q == 2'd0) && !fail_q))

endmodule

`default_nettype wire

@@ rtl/core/utu_emit.sv @@
`default_nettype none
`include "utf8_to_utf16_transcoder_unit_macros.svh"

module utu_emit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             bnd_valid_i,
  output logic                  bnd_ready_o,
  input  wire utu_pkg::bundle_t bnd_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [15:0]           code_unit_o,
  output logic                  is_status_o,
  output logic                  string_error_o,
  output logic                  run_last_o
);

  logic             valid_q, valid_d;
  logic [1:0]       ptr_q, ptr_d;
  utu_pkg::bundle_t bnd_q;
  logic [1:0]       total;
  logic [1:0]       total_in;
  logic             is_unit;
  logic             is_last;
  logic             load;
  logic             take;

  assign total    = bnd_q.n_units + {1'b0, bnd_q.status};
  assign total_in = bnd_i.n_units + {1'b0, bnd_i.status};
  assign is_unit  = ptr_q < bnd_q.n_units;
  assign is_last  = ptr_q == (total - 2'd1);

  assign take        = valid_q && out_ready_i;
  assign bnd_ready_o = !valid_q || (out_ready_i && is_last);
  assign load        = bnd_valid_i && bnd_ready_o;

  // Select the current item of the held bundle
  assign out_valid_o    = valid_q;
  assign code_unit_o    = !is_unit ? 16'h0000 :
                          (ptr_q == 2'd0) ? bnd_q.unit0 : bnd_q.unit1;
  assign is_status_o    = !is_unit;
  assign string_error_o = !is_unit && bnd_q.err;
  assign run_last_o     = is_last;

  // Load a new bundle or advance through the held one
  always_comb begin
    valid_d = valid_q;
    ptr_d   = ptr_q;
    if (load) begin
      valid_d = total_in != 2'd0;
      ptr_d   = 2'd0;
    end else if (take) begin
      if (is_last) begin
        valid_d = 1'b0;
      end else begin
        ptr_d = ptr_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ptr_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bnd_q <= bnd_i;
    end
  end

  `UTU_ASSERT(a_ptr_in_range, clk_i, rst_ni, valid_q |-> (ptr_q < total))
  `UTU_ASSERT(a_status_is_last, clk_i, rst_ni, (valid_q && !is_unit) |-> is_last)
  `UTU_ASSERT(a_drain_on_last, clk_i, rst_ni,
              (take && is_last && !load) |=> !valid_q)

endmodule

`default_nettype wire

@@ tb/tb_utf8_to_utf16_transcoder_unit.sv @@
`default_nettype none

module tb_utf8_to_utf16_transcoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Byte class masks and patterns of UTF-8
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_PAT   = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_PAT   = 8'hE0;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_PAT   = 8'hF0;
  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_PAT    = 8'h80;

  // UTF-16 surrogate construction
  localparam logic [15:0] HIGH_SURR  = 16'hD800;
  localparam logic [15:0] LOW_SURR   = 16'hDC00;
  localparam logic [20:0] PLANE1_MIN = 21'h10000;
  localparam logic [20:0] PLANE_MAX  = 21'h10FFFF;
  localparam logic [20:0] TEN_BITS   = 21'h3FF;

  localparam int CLK_HALF      = 6;
  localparam int HOLD_OFF_LEN  = 64;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 20;

  typedef logic [7:0] byte_seq_t[$];

  typedef struct packed {
    logic [7:0] data;
    logic       string_end;
  } utf8_byte_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_status;
    logic        string_error;
    logic        run_last;
  } utf16_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        s_last = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;
  logic [0:0]  m_user;
  logic        m_last;

  utf8_byte_t    pending_bytes_q[$];
  utf16_result_t expected_units_q[$];

  // Decoder shadow state
  logic [1:0]  dec_pending;
  logic [2:0]  dec_seq_len;
  logic [20:0] dec_code;
  logic        dec_failed;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_req  = 0;
  int hold_off_done = 0;
  int hold_off_left = 0;
  int stall_cycles  = 0;
  int fail_count    = 0;

  utf8_to_utf16_transcoder_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // [7:0] in_byte
    .s_axis_tlast_i  (s_last),   // string_end
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // [15:0] code_unit, [16] string_error
    .m_axis_tuser_o  (m_user),   // [0] is_status
    .m_axis_tlast_o  (m_last)    // run_last
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Decode one accepted byte and queue the results it must produce
  task automatic decode_utf8_byte(input logic [7:0] b, input logic fin);
    logic [15:0]   units[2];
    logic [20:0]   cp;
    int            nu;
    utf16_result_t r;
    nu = 0;
    if (!dec_failed) begin
      if (dec_pending == 2'd0) begin
        if (b < ASCII_LIMIT) begin
          units[nu] = {8'h00, b};
          nu++;
        end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
          dec_code = {16'h0, b[4:0]};
          dec_pending = 2'd1;
          dec_seq_len = 3'd2;
        end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
          dec_code = {17'h0, b[3:0]};
          dec_pending = 2'd2;
          dec_seq_len = 3'd3;
        end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
          dec_code = {18'h0, b[2:0]};
          dec_pending = 2'd3;
          dec_seq_len = 3'd4;
        end else begin
          dec_failed = 1'b1;
        end
      end else if ((b & CONT_MASK) != CONT_PAT) begin
        // Drop the partial sequence
        dec_failed = 1'b1;
        dec_pending = 2'd0;
        dec_seq_len = 3'd0;
        dec_code = '0;
      end else begin
        dec_code = {dec_code[14:0], b[5:0]};
        dec_pending = dec_pending - 2'd1;
        if (dec_pending == 2'd0) begin
          cp = dec_code;
          if (dec_seq_len == 3'd4) begin
            if (cp >= PLANE1_MIN && cp <= PLANE_MAX) begin
              cp = cp - PLANE1_MIN;
              units[0] = HIGH_SURR | 16'((cp >> 10) & TEN_BITS);
              units[1] = LOW_SURR | 16'(cp & TEN_BITS);
              nu = 2;
            end else begin
              dec_failed = 1'b1;
            end
          end else begin
            units[nu] = cp[15:0];
            nu++;
          end
          dec_seq_len = 3'd0;
          dec_code = '0;
        end
      end
    end
    for (int i = 0; i < nu; i++) begin
      r = '{code_unit: units[i], is_status: 1'b0, string_error: 1'b0,
            run_last: (!fin && i == nu - 1)};
      expected_units_q.insert(expected_units_q.size(), r);
    end
    if (fin) begin
      r = '{code_unit: 16'h0, is_status: 1'b1,
            string_error: (dec_failed || dec_pending != 2'd0), run_last: 1'b1};
      expected_units_q.insert(expected_units_q.size(), r);
      dec_pending = 2'd0;
      dec_seq_len = 3'd0;
      dec_code = '0;
      dec_failed = 1'b0;
    end
  endtask

  // Driver: predict on acceptance, then offer the next pending byte
  always @(posedge clk) begin
    if (!rst_n) begin
      dec_pending <= 2'd0;
      dec_seq_len <= 3'd0;
      dec_code <= '0;
      dec_failed <= 1'b0;
    end else begin
      if (s_valid && s_ready) begin
        decode_utf8_byte(s_data, s_last);
      end
      if (!s_valid || s_ready) begin
        if (pending_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_valid <= 1'b1;
          s_data <= pending_bytes_q[0].data;
          s_last <= pending_bytes_q[0].string_end;
          void'(pending_bytes_q.pop_front());
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output item, then pick the next ready level
  always @(posedge clk) begin
    utf16_result_t want;
    if (rst_n) begin
      if (m_valid && m_ready) begin
        if (expected_units_q.size() == 0) begin
          $error("output item with nothing expected: tdata %h tuser %b tlast %b",
                 m_data, m_user, m_last);
          fail_count++;
        end else begin
          want = expected_units_q.pop_front();
          if (m_data[15:0] !== want.code_unit) begin
            $error("code_unit: expected %h, got %h", want.code_unit, m_data[15:0]);
            fail_count++;
          end
          if (m_user[0] !== want.is_status) begin
            $error("is_status: expected %b, got %b", want.is_status, m_user[0]);
            fail_count++;
          end
          if (m_data[16] !== want.string_error) begin
            $error("string_error: expected %b, got %b", want.string_error, m_data[16]);
            fail_count++;
          end
          if (m_last !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, m_last);
            fail_count++;
          end
        end
      end
      if (hold_off_left > 0) begin
        hold_off_left <= hold_off_left - 1;
        m_ready <= 1'b0;
      end else if (hold_off_req != hold_off_done) begin
        hold_off_done <= hold_off_req;
        hold_off_left <= HOLD_OFF_LEN;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when outstanding work makes no progress
  always @(posedge clk) begin
    if (rst_n && (pending_bytes_q.size() != 0 || s_valid || expected_units_q.size() != 0)) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("** utf8_to_utf16_transcoder_unit: FAILED **");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end else begin
      stall_cycles <= 0;
    end
  end

  // Queue one string, marking its last byte
  task automatic push_string(input byte_seq_t seq);
    utf8_byte_t item;
    for (int i = 0; i < seq.size(); i++) begin
      item.data = seq[i];
      item.string_end = (i == seq.size() - 1);
      pending_bytes_q.insert(pending_bytes_q.size(), item);
    end
  endtask

  // Build a mostly well-formed string of random characters, sometimes broken
  task automatic push_random_string(output int n_added);
    byte_seq_t   seq;
    logic [20:0] cp;
    int          n_chars;
    int          len;
    int          r;
    n_chars = $urandom_range(6, 1);
    for (int c = 0; c < n_chars; c++) begin
      len = $urandom_range(4, 1);
      r = $urandom_range(9);
      case (len)
        1: cp = 21'($urandom_range(21'h7F));
        2: cp = (r == 0) ? 21'($urandom_range(21'h7F)) :
                           21'($urandom_range(21'h7FF, 21'h80));
        3: cp = (r == 0) ? 21'($urandom_range(21'h7FF)) :
                           21'($urandom_range(21'hFFFF, 21'h800));
        default: begin
          if (r == 0) cp = 21'($urandom_range(21'h1FFFFF, 21'h110000));
          else if (r == 1) cp = 21'($urandom_range(21'hFFFF));
          else cp = 21'($urandom_range(PLANE_MAX, PLANE1_MIN));
        end
      endcase
      case (len)
        1: seq.insert(seq.size(), {1'b0, cp[6:0]});
        2: begin
          seq.insert(seq.size(), {3'b110, cp[10:6]});
          seq.insert(seq.size(), {2'b10, cp[5:0]});
        end
        3: begin
          seq.insert(seq.size(), {4'b1110, cp[15:12]});
          seq.insert(seq.size(), {2'b10, cp[11:6]});
          seq.insert(seq.size(), {2'b10, cp[5:0]});
        end
        default: begin
          seq.insert(seq.size(), {5'b11110, cp[20:18]});
          seq.insert(seq.size(), {2'b10, cp[17:12]});
          seq.insert(seq.size(), {2'b10, cp[11:6]});
          seq.insert(seq.size(), {2'b10, cp[5:0]});
        end
      endcase
    end
    // Break about one string in five: a random byte, or a cut tail
    r = $urandom_range(9);
    if (r == 0) begin
      seq[$urandom_range(seq.size() - 1)] = 8'($urandom_range(255));
    end else if (r == 1 && seq.size() > 1) begin
      void'(seq.pop_back());
    end
    push_string(seq);
    n_added = seq.size();
  endtask

  task automatic push_random_bytes(input int n_bytes);
    int total;
    int added;
    total = 0;
    while (total < n_bytes) begin
      push_random_string(added);
      total += added;
    end
  endtask

  // Hold the sender until every queued byte has gone and every result arrived
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes_q.size() != 0 || s_valid || expected_units_q.size() != 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Sender idles lightly, receiver heavily; directed strings first
    send_idle_pct = 23;
    recv_idle_pct = 87;
    push_string('{8'h00, 8'h7F});
    push_string('{8'hC2, 8'h80, 8'hDF, 8'hBF});
    push_string('{8'hEF, 8'hBF, 8'hBF, 8'hED, 8'hA0, 8'h80});
    push_string('{8'hF4, 8'h8F, 8'hBF, 8'hBF});
    push_string('{8'hF0, 8'h8F, 8'hBF, 8'hBF, 8'h41});
    push_string('{8'h80});
    push_string('{8'hF8});
    push_string('{8'hFF});
    push_string('{8'hC2, 8'h41});
    push_string('{8'hE2, 8'h82});
    wait_drained();
    push_random_bytes(30);
    wait_drained();

    // Sender idles heavily, receiver lightly
    send_idle_pct = 87;
    recv_idle_pct = 23;
    push_random_bytes(30);
    wait_drained();

    // No idling; receiver holds off long while the sender keeps offering
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req++;
    push_random_bytes(30);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_units_q.size() != 0) begin
      $error("results still expected at end: %0d", expected_units_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("** utf8_to_utf16_transcoder_unit: PASSED **");
    end else begin
      $display("** utf8_to_utf16_transcoder_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
